### rtl/core/ofb_pkg.sv
// Shared types and constants of the page framebuffer flush block.
`default_nettype none
package ofb_pkg;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_FILL_RD,
    ST_FILL_WR,
    ST_CLEAR,
    ST_CMP,
    ST_CMP_TAIL,
    ST_EMIT,
    ST_EMIT_MEM
  } state_e;

  typedef enum logic [2:0] {
    SEG_COLW,
    SEG_PAGEW,
    SEG_DATA,
    SEG_POWER,
    SEG_CONTRAST
  } seg_e;

  localparam logic [2:0] MODE_PIXEL    = 3'd0;
  localparam logic [2:0] MODE_FILL     = 3'd1;
  localparam logic [2:0] MODE_CLEAR    = 3'd2;
  localparam logic [2:0] MODE_FLUSH    = 3'd3;
  localparam logic [2:0] MODE_POWER    = 3'd4;
  localparam logic [2:0] MODE_CONTRAST = 3'd5;

  localparam logic [7:0] LEAD_CMD     = 8'h00;
  localparam logic [7:0] LEAD_DATA    = 8'h40;
  localparam logic [7:0] CMD_COL_WIN  = 8'h21;
  localparam logic [7:0] CMD_PAGE_WIN = 8'h22;
  localparam logic [7:0] CMD_CONTRAST = 8'h81;
  localparam logic [7:0] CMD_DISP_ON  = 8'hAF;
  localparam logic [7:0] CMD_DISP_OFF = 8'hAE;

endpackage
`default_nettype wire

### rtl/core/oled_framebuffer_dirty_page_flush.sv
// Page framebuffer with shadow copy and dirty-page flush to packed bus words.
//
// Input items arrive on s_tvalid_i/s_tready_o with the mode in s_tuser_i.
// Modes: pixel, fill rectangle, clear, flush page, display power, contrast.
// The block takes one item at a time; s_tready_o is high only when idle.
// Pixel and fill do a read-modify-write on the frame RAM for each touched
// byte (page by column), a read state then a write state. Clear writes one
// frame byte a cycle over all COLUMNS*PAGE_COUNT bytes. A flush without
// force compares the page with the shadow RAM. A sent page then goes out
// byte by byte, each data byte read from the frame RAM and then written to
// the shadow RAM, packed into words of up to eight bytes on m_tvalid_o and
// m_tready_i; m_tlast_o marks the final word of the item. A stalled
// receiver holds the output register and the sequencer waits for it. After
// reset both RAMs are swept to zero, one address a cycle over all
// COLUMNS*PAGE_COUNT addresses, during which no item is accepted.
// The configuration channel (cfg_valid_i/cfg_ready_o) is always ready.
`default_nettype none
module oled_framebuffer_dirty_page_flush
  import ofb_pkg::*;
#(
  parameter int COLUMNS     = 128,
  parameter int PAGE_COUNT  = 8,
  parameter int CHUNK_BYTES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [6:0]  cfg_data_i,
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  // pos_x[15:0] pos_y[31:16] rect_width[47:32] rect_height[63:48] ink[64]
  // page_index[67:65] force_req[68] level[76:69]
  input  wire logic [79:0] s_tdata_i,
  // mode[2:0]
  input  wire logic [2:0]  s_tuser_i,
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  // bus_bytes[63:0] byte_count[67:64] txn_start[68] txn_end[69]
  // target_address[76:70]
  output logic [79:0]      m_tdata_o,
  output logic             m_tlast_o
);

  localparam int DEPTH = COLUMNS * PAGE_COUNT;
  localparam int AW    = $clog2(DEPTH);
  localparam int ROWS  = PAGE_COUNT * 8;

  state_e      state_q, state_d;
  seg_e        seg_q, seg_d;
  logic [5:0]  tpos_q, tpos_d, tlen_q, tlen_d;
  logic [7:0]  sent_q, sent_d;
  logic [AW-1:0] daddr_q, daddr_d, cnt_q, cnt_d;
  logic [2:0]  page_q, page_d;
  logic        ink_q, ink_d;
  logic [7:0]  level_q, level_d;
  logic [63:0] wbuf_q, wbuf_d;
  logic [2:0]  wcnt_q, wcnt_d;
  logic        wstart_q, wstart_d;
  logic [7:0]  fx_q, fx_d, x0_q, x0_d, x1_q, x1_d, y0_q, y0_d, y1_q, y1_d;
  logic [2:0]  fp_q, fp_d, fpend_q, fpend_d;
  logic        cmpv_q, diff_q, diff_d;
  logic        ov_q, ov_d, olast_q, olast_d;
  logic [79:0] odata_q, odata_d;
  logic [6:0]  dev_q;

  logic          fr_we, fr_re, sh_we, sh_re;
  logic [AW-1:0] fr_waddr, fr_raddr, sh_waddr, sh_raddr;
  logic [7:0]    fr_wdata, sh_wdata, fr_rdata, sh_rdata;

  logic [AW-1:0] faddr, caddr;
  logic [7:0]    fmask;
  logic [7:0]    cbyte;
  logic          is_final;

  function automatic logic [7:0] clip(input logic signed [16:0] v, input logic [7:0] lim);
    logic [7:0] r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v > $signed({9'd0, lim})) begin
      r = lim;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  function automatic logic [5:0] chunk_len(input logic [7:0] sent);
    logic [7:0] rem;
    rem = 8'(COLUMNS) - sent;
    return (rem > 8'(CHUNK_BYTES)) ? 6'(CHUNK_BYTES) : rem[5:0];
  endfunction

  assign cfg_ready_o = 1'b1;
  assign s_tready_o  = (state_q == ST_IDLE);
  assign m_tvalid_o  = ov_q;
  assign m_tdata_o   = odata_q;
  assign m_tlast_o   = olast_q;

  assign faddr = AW'(11'(fp_q) * 11'(COLUMNS) + 11'(fx_q));
  assign caddr = daddr_q + cnt_q;

  always_comb begin
    for (int r = 0; r < 8; r++) begin
      fmask[r] = ({2'b00, fp_q, 3'(r)} >= y0_q) && ({2'b00, fp_q, 3'(r)} < y1_q);
    end
  end

  always_comb begin
    cbyte = LEAD_CMD;
    case (seg_q)
      SEG_COLW: begin
        case (tpos_q[1:0])
          2'd1:    cbyte = CMD_COL_WIN;
          2'd3:    cbyte = 8'(COLUMNS - 1);
          default: cbyte = LEAD_CMD;
        endcase
      end
      SEG_PAGEW: begin
        case (tpos_q[1:0])
          2'd0:    cbyte = LEAD_CMD;
          2'd1:    cbyte = CMD_PAGE_WIN;
          default: cbyte = {5'd0, page_q};
        endcase
      end
      SEG_DATA:  cbyte = LEAD_DATA;
      SEG_POWER: cbyte = (tpos_q == 6'd0) ? LEAD_CMD : (ink_q ? CMD_DISP_ON : CMD_DISP_OFF);
      SEG_CONTRAST: begin
        case (tpos_q[1:0])
          2'd0:    cbyte = LEAD_CMD;
          2'd1:    cbyte = CMD_CONTRAST;
          default: cbyte = level_q;
        endcase
      end
      default: cbyte = LEAD_CMD;
    endcase
  end

  assign is_final = (seg_q == SEG_POWER) || (seg_q == SEG_CONTRAST) ||
                    ((seg_q == SEG_DATA) &&
                     ((9'(sent_q) + 9'(tlen_q) - 9'd1) >= 9'(COLUMNS)));

  // next state and datapath
  always_comb begin
    logic signed [16:0] px, py, pw, ph;
    logic [2:0]  mode;
    logic [7:0]  b, ny1;
    logic        bvalid, full, tend, push, go, can_push, start_eff;
    logic [63:0] wnew;
    logic [7:0]  sent_new;

    state_d  = state_q;
    seg_d    = seg_q;
    tpos_d   = tpos_q;
    tlen_d   = tlen_q;
    sent_d   = sent_q;
    daddr_d  = daddr_q;
    cnt_d    = cnt_q;
    page_d   = page_q;
    ink_d    = ink_q;
    level_d  = level_q;
    wbuf_d   = wbuf_q;
    wcnt_d   = wcnt_q;
    wstart_d = wstart_q;
    fx_d     = fx_q;
    x0_d     = x0_q;
    x1_d     = x1_q;
    y0_d     = y0_q;
    y1_d     = y1_q;
    fp_d     = fp_q;
    fpend_d  = fpend_q;
    odata_d  = odata_q;
    olast_d  = olast_q;
    can_push = !ov_q || m_tready_i;
    ov_d     = ov_q && !m_tready_i;
    diff_d   = diff_q || (cmpv_q && (fr_rdata != sh_rdata));

    mode = s_tuser_i;
    px   = 17'(signed'(s_tdata_i[15:0]));
    py   = 17'(signed'(s_tdata_i[31:16]));
    pw   = 17'(signed'(s_tdata_i[47:32]));
    ph   = 17'(signed'(s_tdata_i[63:48]));
    ny1  = 8'd0;

    b         = (state_q == ST_EMIT_MEM) ? fr_rdata : cbyte;
    bvalid    = (state_q == ST_EMIT_MEM) ||
                ((state_q == ST_EMIT) && !((seg_q == SEG_DATA) && (tpos_q != 6'd0)));
    full      = (wcnt_q == 3'd7);
    tend      = ((tpos_q + 6'd1) == tlen_q);
    push      = full || tend;
    go        = !push || can_push;
    start_eff = (wcnt_q == 3'd0) ? (tpos_q == 6'd0) : wstart_q;
    wnew      = wbuf_q | (64'(b) << {wcnt_q, 3'b000});
    sent_new  = sent_q + 8'(tlen_q) - 8'd1;

    case (state_q)
      ST_INIT: begin
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        diff_d = 1'b0;
        if (s_tvalid_i) begin
          ink_d   = s_tdata_i[64];
          page_d  = s_tdata_i[67:65];
          level_d = s_tdata_i[76:69];
          tpos_d  = 6'd0;
          wcnt_d  = 3'd0;
          wbuf_d  = 64'd0;
          cnt_d   = '0;
          case (mode)
            MODE_PIXEL, MODE_FILL: begin
              if (mode == MODE_PIXEL) begin
                pw = 17'sd1;
                ph = 17'sd1;
              end
              x0_d    = clip(px, 8'(COLUMNS));
              x1_d    = clip(px + pw, 8'(COLUMNS));
              y0_d    = clip(py, 8'(ROWS));
              ny1     = clip(py + ph, 8'(ROWS));
              y1_d    = ny1;
              fx_d    = x0_d;
              fp_d    = y0_d[5:3];
              fpend_d = 3'((ny1 - 8'd1) >> 3);
              if ((x0_d < x1_d) && (y0_d < ny1)) begin
                state_d = ST_FILL_RD;
              end
            end
            MODE_CLEAR: state_d = ST_CLEAR;
            MODE_FLUSH: begin
              if ({1'b0, s_tdata_i[67:65]} < 4'(PAGE_COUNT)) begin
                daddr_d = AW'(11'(s_tdata_i[67:65]) * 11'(COLUMNS));
                seg_d   = SEG_COLW;
                tlen_d  = 6'd4;
                state_d = s_tdata_i[68] ? ST_EMIT : ST_CMP;
              end
            end
            MODE_POWER: begin
              seg_d   = SEG_POWER;
              tlen_d  = 6'd2;
              state_d = ST_EMIT;
            end
            MODE_CONTRAST: begin
              seg_d   = SEG_CONTRAST;
              tlen_d  = 6'd3;
              state_d = ST_EMIT;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_FILL_RD: state_d = ST_FILL_WR;
      ST_FILL_WR: begin
        state_d = ST_FILL_RD;
        if (fx_q == (x1_q - 8'd1)) begin
          fx_d = x0_q;
          fp_d = fp_q + 3'd1;
          if (fp_q == fpend_q) begin
            state_d = ST_IDLE;
          end
        end else begin
          fx_d = fx_q + 8'd1;
        end
      end
      ST_CLEAR: begin
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_CMP: begin
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == AW'(COLUMNS - 1)) begin
          state_d = ST_CMP_TAIL;
        end
      end
      ST_CMP_TAIL: state_d = diff_d ? ST_EMIT : ST_IDLE;
      ST_EMIT, ST_EMIT_MEM: begin
        if (!bvalid) begin
          state_d = ST_EMIT_MEM;
        end else if (go) begin
          if (state_q == ST_EMIT_MEM) begin
            daddr_d = daddr_q + AW'(1);
          end
          state_d = ST_EMIT;
          if (push) begin
            ov_d    = 1'b1;
            odata_d = {3'd0, dev_q, tend, start_eff, {1'b0, wcnt_q} + 4'd1, wnew};
            olast_d = tend && is_final;
            wbuf_d  = 64'd0;
            wcnt_d  = 3'd0;
          end else begin
            wbuf_d   = wnew;
            wcnt_d   = wcnt_q + 3'd1;
            wstart_d = start_eff;
          end
          tpos_d = tend ? 6'd0 : tpos_q + 6'd1;
          if (tend) begin
            case (seg_q)
              SEG_COLW: begin
                seg_d  = SEG_PAGEW;
                tlen_d = 6'd4;
              end
              SEG_PAGEW: begin
                seg_d  = SEG_DATA;
                sent_d = 8'd0;
                tlen_d = chunk_len(8'd0) + 6'd1;
              end
              SEG_DATA: begin
                sent_d = sent_new;
                tlen_d = chunk_len(sent_new) + 6'd1;
                if (is_final) begin
                  state_d = ST_IDLE;
                end
              end
              default: state_d = ST_IDLE;
            endcase
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    fr_we    = 1'b0;
    fr_re    = 1'b0;
    sh_we    = 1'b0;
    sh_re    = 1'b0;
    fr_waddr = faddr;
    fr_raddr = faddr;
    sh_waddr = daddr_q;
    sh_raddr = caddr;
    fr_wdata = ink_q ? (fr_rdata | fmask) : (fr_rdata & ~fmask);
    sh_wdata = fr_rdata;
    case (state_q)
      ST_INIT: begin
        fr_we    = 1'b1;
        sh_we    = 1'b1;
        fr_waddr = cnt_q;
        sh_waddr = cnt_q;
        fr_wdata = 8'd0;
        sh_wdata = 8'd0;
      end
      ST_CLEAR: begin
        fr_we    = 1'b1;
        fr_waddr = cnt_q;
        fr_wdata = 8'd0;
      end
      ST_CMP: begin
        fr_re    = 1'b1;
        sh_re    = 1'b1;
        fr_raddr = caddr;
      end
      ST_FILL_RD: fr_re = 1'b1;
      ST_FILL_WR: fr_we = 1'b1;
      ST_EMIT: begin
        if ((seg_q == SEG_DATA) && (tpos_q != 6'd0)) begin
          fr_re    = 1'b1;
          fr_raddr = daddr_q;
        end
      end
      ST_EMIT_MEM: sh_we = 1'b1;
      default: fr_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
      cmpv_q  <= 1'b0;
      diff_q  <= 1'b0;
      dev_q   <= 7'd60;
      seg_q   <= SEG_COLW;
      tpos_q  <= 6'd0;
      tlen_q  <= 6'd4;
      wcnt_q  <= 3'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
      cmpv_q  <= (state_q == ST_CMP);
      diff_q  <= diff_d;
      seg_q   <= seg_d;
      tpos_q  <= tpos_d;
      tlen_q  <= tlen_d;
      wcnt_q  <= wcnt_d;
      if (cfg_valid_i) begin
        dev_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sent_q   <= sent_d;
    daddr_q  <= daddr_d;
    page_q   <= page_d;
    ink_q    <= ink_d;
    level_q  <= level_d;
    wbuf_q   <= wbuf_d;
    wstart_q <= wstart_d;
    fx_q     <= fx_d;
    x0_q     <= x0_d;
    x1_q     <= x1_d;
    y0_q     <= y0_d;
    y1_q     <= y1_d;
    fp_q     <= fp_d;
    fpend_q  <= fpend_d;
    odata_q  <= odata_d;
    olast_q  <= olast_d;
  end

  ofb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (fr_waddr),
    .wdata_i (fr_wdata),
    .re_i    (fr_re),
    .raddr_i (fr_raddr),
    .rdata_o (fr_rdata)
  );

  ofb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_shadow_ram (
    .clk_i   (clk_i),
    .we_i    (sh_we),
    .waddr_i (sh_waddr),
    .wdata_i (sh_wdata),
    .re_i    (sh_re),
    .raddr_i (sh_raddr),
    .rdata_o (sh_rdata)
  );

endmodule
`default_nettype wire

### rtl/core/ofb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ofb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire
